// ===== rtl/qvt_pkg.sv =====
// shared types and constants of the quaternion vertex transform
package qvt_pkg;

  localparam int COORD_W = 32;
  localparam int TAG_W = 16;
  localparam int QC_W = 16;
  localparam int SCALE_W = 16;
  localparam int QUAT_W = 4 * QC_W;
  localparam int QPROD_W = 2 * QC_W;
  localparam int R_W = 34;
  localparam int RS_W = R_W + SCALE_W;
  localparam int MAT_FRAC_SHIFT = 20;
  localparam int ACC_W = 64;
  localparam int OUT_FRAC_SHIFT = 16;
  localparam int Q_W = ACC_W - OUT_FRAC_SHIFT;
  localparam int NUM_AXES = 3;
  localparam int NUM_ENT = NUM_AXES * NUM_AXES;

  localparam int IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_ROT = 3'd0;
  localparam logic [IDX_W-1:0] REG_SCALE_X = 3'd1;
  localparam logic [IDX_W-1:0] REG_SCALE_Y = 3'd2;
  localparam logic [IDX_W-1:0] REG_SCALE_Z = 3'd3;
  localparam logic [IDX_W-1:0] REG_OFF_X = 3'd4;
  localparam logic [IDX_W-1:0] REG_OFF_Y = 3'd5;
  localparam logic [IDX_W-1:0] REG_OFF_Z = 3'd6;

  // matrix refresh: product, sum, scale, round stages
  localparam int BUILD_LAT = 4;
  localparam int BUILD_CNT_W = $clog2(BUILD_LAT + 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [NUM_AXES-1:0] vec_t;
  typedef coord_t [NUM_ENT-1:0] matrix_t;
  typedef logic signed [SCALE_W-1:0] scale_t;

  typedef struct packed {
    logic [QUAT_W-1:0] quat;
    scale_t            scale_x;
    scale_t            scale_y;
    scale_t            scale_z;
    vec_t              offset;
  } cfg_t;

  localparam logic signed [R_W-1:0] R_ONE = R_W'(64'sd1 <<< 28);
  localparam logic signed [RS_W-1:0] MAT_HALF = RS_W'(64'sd1 <<< (MAT_FRAC_SHIFT - 1));
  localparam logic signed [ACC_W-1:0] OUT_HALF = ACC_W'(64'sd1 <<< (OUT_FRAC_SHIFT - 1));
  localparam coord_t COORD_MAX = 32'sh7fff_ffff;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

  localparam logic [QUAT_W-1:0] QUAT_RESET = 64'h4000_0000_0000_0000;
  localparam scale_t SCALE_ONE = 16'sd256;
  localparam coord_t OFFSET_ZERO = 32'sd0;

endpackage

// ===== rtl/qvt_matrix_build.sv =====
// pipelined rebuild of the scaled rotation matrix from the register set
module qvt_matrix_build
  import qvt_pkg::*;
(
  input  logic    clk,
  input  cfg_t    cfg,
  output matrix_t matrix
);

  logic signed [QC_W-1:0] qx, qy, qz, qw;
  scale_t sc [NUM_AXES];

  logic signed [QPROD_W-1:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
  logic signed [R_W-1:0] r [NUM_ENT];
  logic signed [RS_W-1:0] p [NUM_ENT];
  logic signed [RS_W-1:0] rnd [NUM_ENT];

  assign qx = cfg.quat[QC_W-1:0];
  assign qy = cfg.quat[2*QC_W-1:QC_W];
  assign qz = cfg.quat[3*QC_W-1:2*QC_W];
  assign qw = cfg.quat[4*QC_W-1:3*QC_W];
  assign sc[0] = cfg.scale_x;
  assign sc[1] = cfg.scale_y;
  assign sc[2] = cfg.scale_z;

  // quaternion products
  always_ff @(posedge clk) begin
    xx <= qx * qx;
    yy <= qy * qy;
    zz <= qz * qz;
    xy <= qx * qy;
    xz <= qx * qz;
    yz <= qy * qz;
    xw <= qx * qw;
    yw <= qy * qw;
    zw <= qz * qw;
  end

  // rotation entries in q.28
  always_ff @(posedge clk) begin
    r[0] <= R_ONE - ((R_W'(yy) + R_W'(zz)) <<< 1);
    r[1] <= (R_W'(xy) - R_W'(zw)) <<< 1;
    r[2] <= (R_W'(xz) + R_W'(yw)) <<< 1;
    r[3] <= (R_W'(xy) + R_W'(zw)) <<< 1;
    r[4] <= R_ONE - ((R_W'(xx) + R_W'(zz)) <<< 1);
    r[5] <= (R_W'(yz) - R_W'(xw)) <<< 1;
    r[6] <= (R_W'(xz) - R_W'(yw)) <<< 1;
    r[7] <= (R_W'(yz) + R_W'(xw)) <<< 1;
    r[8] <= R_ONE - ((R_W'(xx) + R_W'(yy)) <<< 1);
  end

  // column scaling
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_ENT; k++) begin
      p[k] <= RS_W'(r[k]) * RS_W'(sc[k % NUM_AXES]);
    end
  end

  // round to q16.16
  always_comb begin
    for (int k = 0; k < NUM_ENT; k++) begin
      rnd[k] = p[k] + MAT_HALF;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_ENT; k++) begin
      matrix[k] <= COORD_W'(rnd[k] >>> MAT_FRAC_SHIFT);
    end
  end

endmodule

// ===== rtl/qvt_vertex_pipe.sv =====
// five stage vertex datapath: input register, multiply, partial sums, round, saturate
module qvt_vertex_pipe
  import qvt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  vec_t             in_vec,
  input  logic [TAG_W-1:0] in_tag,
  input  matrix_t          matrix,
  input  vec_t             offset,
  output logic             out_valid,
  input  logic             out_ready,
  output vec_t             out_vec,
  output logic [TAG_W-1:0] out_tag,
  output logic             out_ovf
);

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  vec_t vec1;
  logic [TAG_W-1:0] tag1, tag2, tag3, tag4;
  logic signed [ACC_W-1:0] prod2 [NUM_ENT];
  logic signed [ACC_W-1:0] suma3 [NUM_AXES];
  logic signed [ACC_W-1:0] sumb3 [NUM_AXES];
  logic signed [Q_W-1:0] q4 [NUM_AXES];
  logic signed [ACC_W-1:0] acc [NUM_AXES];
  vec_t sat_vec;
  logic sat_ovf;

  assign rdy5 = !out_valid || out_ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) out_valid <= v4;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rdy1) begin
      vec1 <= in_vec;
      tag1 <= in_tag;
    end
  end

  // matrix times vertex products
  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        for (int j = 0; j < NUM_AXES; j++) begin
          prod2[i*NUM_AXES+j] <= ACC_W'($signed(matrix[i*NUM_AXES+j]))
                                 * ACC_W'($signed(vec1[j]));
        end
      end
      tag2 <= tag1;
    end
  end

  // partial sums with translation in q32.32
  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        suma3[i] <= prod2[i*NUM_AXES] + prod2[i*NUM_AXES+1];
        sumb3[i] <= prod2[i*NUM_AXES+2]
                    + (ACC_W'($signed(offset[i])) <<< OUT_FRAC_SHIFT);
      end
      tag3 <= tag2;
    end
  end

  // final sum and rounding
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      acc[i] = suma3[i] + sumb3[i] + OUT_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        q4[i] <= Q_W'(acc[i] >>> OUT_FRAC_SHIFT);
      end
      tag4 <= tag3;
    end
  end

  // clamp to q16.16
  always_comb begin
    sat_ovf = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (q4[i][Q_W-1:COORD_W-1] == '0 || q4[i][Q_W-1:COORD_W-1] == '1) begin
        sat_vec[i] = q4[i][COORD_W-1:0];
      end else begin
        sat_vec[i] = q4[i][Q_W-1] ? COORD_MIN : COORD_MAX;
        sat_ovf = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      out_vec <= sat_vec;
      out_tag <= tag4;
      out_ovf <= sat_ovf;
    end
  end

endmodule

// ===== rtl/quaternion_model_vertex_transform_core.sv =====
// top level of the quaternion, scale and translate vertex transform
//
// Takes one vertex per cycle unless the output side or a matrix refresh stalls
// it; each position passes the input, product, sum, round and output registers.
// Each result is a fully pipelined matrix multiply (three signed 32x32 products
// per axis), a translation add, round-to-nearest and saturation to q16.16, with
// overflow on m_tuser. The 3x3 matrix comes from a four stage rebuild pipeline
// (quaternion products, rotation terms, column scaling, rounding); after reset
// and after every register write s_tready stays low while that pipeline refreshes
// the matrix. The user must write registers only while the block is idle; the
// block does not enforce it, and ignores cfg_index values past the last register.
module quaternion_model_vertex_transform_core
  import qvt_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  // slave stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [3*COORD_W+TAG_W-1:0]    s_tdata,  // vertex_x, vertex_y, vertex_z, vertex_tag
  // master stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [3*COORD_W+TAG_W-1:0]    m_tdata,  // world_x, world_y, world_z, result_tag
  output logic                          m_tuser,  // overflow
  // register write port
  input  logic                          cfg_we,
  input  logic [IDX_W-1:0]              cfg_index,
  input  logic [QUAT_W-1:0]             cfg_data
);

  cfg_t cfg;
  logic [BUILD_CNT_W-1:0] build_cnt;
  logic build_idle;
  matrix_t matrix;
  logic pipe_ready;
  vec_t in_vec;
  vec_t out_vec;
  logic [TAG_W-1:0] out_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quat <= QUAT_RESET;
      cfg.scale_x <= SCALE_ONE;
      cfg.scale_y <= SCALE_ONE;
      cfg.scale_z <= SCALE_ONE;
      cfg.offset <= {NUM_AXES{OFFSET_ZERO}};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROT:     cfg.quat <= cfg_data;
        REG_SCALE_X: cfg.scale_x <= cfg_data[SCALE_W-1:0];
        REG_SCALE_Y: cfg.scale_y <= cfg_data[SCALE_W-1:0];
        REG_SCALE_Z: cfg.scale_z <= cfg_data[SCALE_W-1:0];
        REG_OFF_X:   cfg.offset[0] <= cfg_data[COORD_W-1:0];
        REG_OFF_Y:   cfg.offset[1] <= cfg_data[COORD_W-1:0];
        REG_OFF_Z:   cfg.offset[2] <= cfg_data[COORD_W-1:0];
        default:     ;
      endcase
    end
  end

  // hold off input until the matrix reflects the registers
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      build_cnt <= BUILD_CNT_W'(BUILD_LAT);
    end else if (build_cnt != '0) begin
      build_cnt <= build_cnt - 1'b1;
    end
  end

  assign build_idle = (build_cnt == '0);
  assign s_tready = pipe_ready && build_idle;

  assign in_vec[0] = s_tdata[COORD_W-1:0];
  assign in_vec[1] = s_tdata[2*COORD_W-1:COORD_W];
  assign in_vec[2] = s_tdata[3*COORD_W-1:2*COORD_W];

  qvt_matrix_build u_build (
    .clk    (clk),
    .cfg    (cfg),
    .matrix (matrix)
  );

  qvt_vertex_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid && build_idle),
    .in_ready  (pipe_ready),
    .in_vec    (in_vec),
    .in_tag    (s_tdata[3*COORD_W+TAG_W-1:3*COORD_W]),
    .matrix    (matrix),
    .offset    (cfg.offset),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_vec   (out_vec),
    .out_tag   (out_tag),
    .out_ovf   (m_tuser)
  );

  assign m_tdata = {out_tag, out_vec[2], out_vec[1], out_vec[0]};

`ifndef SYNTHESIS
  // no transaction right after a register write
  assert property (@(posedge clk) disable iff (rst) cfg_we |=> !s_tready)
    else $error("input accepted during matrix refresh");

  // overflow only with a clamped coordinate
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |->
      (m_tdata[COORD_W-1:0] == COORD_MAX || m_tdata[COORD_W-1:0] == COORD_MIN ||
       m_tdata[2*COORD_W-1:COORD_W] == COORD_MAX ||
       m_tdata[2*COORD_W-1:COORD_W] == COORD_MIN ||
       m_tdata[3*COORD_W-1:2*COORD_W] == COORD_MAX ||
       m_tdata[3*COORD_W-1:2*COORD_W] == COORD_MIN))
    else $error("overflow without a saturated coordinate");

  // output empty after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule
